// ===== rtl/core/lpsc_pkg.sv =====
// shared types and constants for the length prefix to start code core
`default_nettype none

package lpsc_pkg;

   localparam int DATA_W              = 8;
   localparam int SIZE_W              = 13;
   localparam int COUNT_W             = 4;
   localparam int LENGTH_W            = 32;
   localparam int PREFIX_BYTES        = 4;
   localparam int BLOCK_BYTES_DEFAULT = 4096;
   localparam int SHORT_BLOCK_BYTES   = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
   localparam logic [COUNT_W-1:0] COUNT_GOOD_A = 4'd2;
   localparam logic [COUNT_W-1:0] COUNT_GOOD_B = 4'd4;

   localparam logic [DATA_W-1:0] START_CODE_ZERO = 8'h00;
   localparam logic [DATA_W-1:0] START_CODE_LAST = 8'h01;

   typedef enum logic [1:0] {
      STATUS_NONE  = 2'd0,
      STATUS_OK    = 2'd1,
      STATUS_COUNT = 2'd2,
      STATUS_SHORT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PFX_IDLE  = 3'd0,
      PFX_BYTE1 = 3'd1,
      PFX_BYTE2 = 3'd2,
      PFX_BYTE3 = 3'd3,
      PFX_BYTE4 = 3'd4
   } prefix_index_type;

endpackage

`default_nettype wire

// ===== rtl/core/length_prefix_to_start_code_core.sv =====
// top level: rewrites 4-byte length prefixes of a block into start codes
//
// Bytes of one block enter one per transaction with the block size; each leaves in the
// cycle after it is taken, in a single result register, with 4-byte big-endian length
// prefixes replaced by 00 00 00 01, a running NAL unit count and, on the last byte, the
// block status. Throughput is one byte per clock: all per-byte work (the position
// compares, one add of the prefix length to the position) sits between the request port
// and the result register, and a new byte is taken whenever that register is empty or
// being drained. Block sizes of zero count as one, sizes above BLOCK_BYTES are clipped
// to BLOCK_BYTES.
`default_nettype none

module length_prefix_to_start_code_core #(
   parameter int BLOCK_BYTES = lpsc_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lpsc_pkg::DATA_W-1:0]   req_data_byte,
   input  wire logic [lpsc_pkg::SIZE_W-1:0]   req_block_size,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lpsc_pkg::DATA_W-1:0]        rsp_out_byte,
   output logic                               rsp_block_end,
   output logic [1:0]                         rsp_status,
   output logic [lpsc_pkg::COUNT_W-1:0]       rsp_nal_count
);

   localparam int PW = $clog2(BLOCK_BYTES);
   localparam int SW = (PW + 1 > lpsc_pkg::SIZE_W) ? PW + 1 : lpsc_pkg::SIZE_W;
   localparam int AW = PW + 2;

   logic [PW-1:0]                    pos_ff, pos_in;
   logic [PW-1:0]                    next_pos_ff, next_pos_in;
   logic                             beyond_ff, beyond_in;
   lpsc_pkg::prefix_index_type       idx_ff, idx_in;
   logic [23:0]                      acc_ff, acc_in;
   logic [lpsc_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;

   logic                             rsp_valid_ff;
   logic [lpsc_pkg::DATA_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                             rsp_end_ff, rsp_end_in;
   lpsc_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [lpsc_pkg::COUNT_W-1:0]     rsp_cnt_ff;

   logic                             accept;
   logic [SW-1:0]                    size_raw;
   logic [SW-1:0]                    size_c;
   logic [SW-1:0]                    pos_ext;
   logic                             start;
   logic                             in_prefix;
   lpsc_pkg::prefix_index_type       cur_idx;
   logic                             last;
   logic [lpsc_pkg::LENGTH_W-1:0]    len_full;
   logic                             len_high_nz;
   logic [AW-1:0]                    sum;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign size_raw = SW'(req_block_size);
   assign pos_ext  = SW'(pos_ff);

   always_comb begin
      if (size_raw == '0) begin
         size_c = SW'(1);
      end else if (size_raw > SW'(BLOCK_BYTES)) begin
         size_c = SW'(BLOCK_BYTES);
      end else begin
         size_c = size_raw;
      end
   end

   assign start = (idx_ff == lpsc_pkg::PFX_IDLE) && !beyond_ff && (pos_ff == next_pos_ff)
                  && (pos_ext + SW'(lpsc_pkg::PREFIX_BYTES) < size_c);
   assign in_prefix = start || (idx_ff != lpsc_pkg::PFX_IDLE);
   assign cur_idx   = start ? lpsc_pkg::PFX_BYTE1 : idx_ff;
   assign last      = (pos_ext + SW'(1) >= size_c);

   assign len_full    = {acc_ff, req_data_byte};
   assign len_high_nz = |len_full[lpsc_pkg::LENGTH_W-1:PW];
   assign sum         = AW'(pos_ff) + AW'(1) + AW'(len_full[PW-1:0]);

   always_comb begin
      pos_in        = pos_ff;
      next_pos_in   = next_pos_ff;
      beyond_in     = beyond_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      rsp_byte_in   = req_data_byte;
      rsp_status_in = lpsc_pkg::STATUS_NONE;
      rsp_end_in    = last;

      if (start && cnt_ff != lpsc_pkg::COUNT_MAX) begin
         cnt_in = cnt_ff + lpsc_pkg::COUNT_W'(1);
      end

      if (in_prefix) begin
         acc_in = start ? {16'h0000, req_data_byte} : {acc_ff[15:0], req_data_byte};
         if (cur_idx == lpsc_pkg::PFX_BYTE4) begin
            rsp_byte_in = lpsc_pkg::START_CODE_LAST;
            next_pos_in = sum[PW-1:0];
            beyond_in   = len_high_nz || (sum >= AW'(BLOCK_BYTES));
            idx_in      = lpsc_pkg::PFX_IDLE;
         end else begin
            rsp_byte_in = lpsc_pkg::START_CODE_ZERO;
            idx_in      = lpsc_pkg::prefix_index_type'(cur_idx + 3'd1);
         end
      end

      if (last) begin
         if (size_c < SW'(lpsc_pkg::SHORT_BLOCK_BYTES)) begin
            rsp_status_in = lpsc_pkg::STATUS_SHORT;
         end else if (cnt_in == lpsc_pkg::COUNT_GOOD_A || cnt_in == lpsc_pkg::COUNT_GOOD_B) begin
            rsp_status_in = lpsc_pkg::STATUS_OK;
         end else begin
            rsp_status_in = lpsc_pkg::STATUS_COUNT;
         end
         pos_in      = '0;
         next_pos_in = '0;
         beyond_in   = 1'b0;
         idx_in      = lpsc_pkg::PFX_IDLE;
      end else begin
         pos_in = pos_ff + PW'(1);
      end
   end

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         next_pos_ff <= '0;
         beyond_ff   <= 1'b0;
         idx_ff      <= lpsc_pkg::PFX_IDLE;
         acc_ff      <= '0;
         cnt_ff      <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         next_pos_ff <= next_pos_in;
         beyond_ff   <= beyond_in;
         idx_ff      <= idx_in;
         acc_ff      <= acc_in;
         cnt_ff      <= last ? '0 : cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_status_ff <= rsp_status_in;
         rsp_cnt_ff    <= cnt_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_block_end = rsp_end_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_nal_count = rsp_cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lpsc_checker.sv =====
// port-level checker for the length prefix to start code core, with its bind
`default_nettype none

module lpsc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [lpsc_pkg::DATA_W-1:0]   rsp_out_byte,
   input wire logic                          rsp_block_end,
   input wire logic [1:0]                    rsp_status,
   input wire logic [lpsc_pkg::COUNT_W-1:0]  rsp_nal_count
);

   // stalled transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_nal_count))
      else $error("stalled result changed");

   // input is only held back by a full, stalled result register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without backpressure");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_block_end |-> rsp_status == lpsc_pkg::STATUS_NONE)
      else $error("status reported before block end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_status != lpsc_pkg::STATUS_NONE)
      else $error("block end without status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lpsc_pkg::STATUS_OK |->
         rsp_nal_count == lpsc_pkg::COUNT_GOOD_A || rsp_nal_count == lpsc_pkg::COUNT_GOOD_B)
      else $error("ok status with wrong unit count");

endmodule

bind length_prefix_to_start_code_core lpsc_checker u_lpsc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_block_end (rsp_block_end),
   .rsp_status    (rsp_status),
   .rsp_nal_count (rsp_nal_count)
);

`default_nettype wire
